>>> sv/bet_pkg.sv
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types, codes and helper functions of the boolean expression
// tokenizer: character classes, token kinds and the record format of the
// queue between the front and back parts.
// ----------------------------------------------------------------------------
package bet_pkg;

	// Default width of the line and column counters.
	localparam int unsigned POS_BITS_DEF = 16;

	// Width of a position field on the result port.
	localparam int unsigned OUT_POS_W = 16;

	// Number of records the queue between front and back can hold.
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Character classes; the first seven also name the pending token.
	typedef enum logic [3:0] {
		CLS_NONE   = 4'd0,
		CLS_IDENT  = 4'd1,
		CLS_NOT    = 4'd2,
		CLS_LPAREN = 4'd3,
		CLS_RPAREN = 4'd4,
		CLS_AMP    = 4'd5,
		CLS_BAR    = 4'd6,
		CLS_SPACE  = 4'd7,
		CLS_DIGIT  = 4'd8,
		CLS_OTHER  = 4'd9
	} cls_t;

	// Token kinds as seen on the result port.
	typedef enum logic [2:0] {
		KIND_IDENT  = 3'd0,
		KIND_NOT    = 3'd1,
		KIND_LPAREN = 3'd2,
		KIND_RPAREN = 3'd3,
		KIND_AND    = 3'd4,
		KIND_OR     = 3'd5,
		KIND_ERROR  = 3'd6,
		KIND_END    = 3'd7
	} kind_t;

	// One result token with its positions already cut to the port width.
	typedef struct packed {
		kind_t                 kind;
		logic [OUT_POS_W-1:0]  first_line;
		logic [OUT_POS_W-1:0]  first_column;
		logic [OUT_POS_W-1:0]  final_line;
		logic [OUT_POS_W-1:0]  final_column;
	} tok_t;

	// All results that one item causes: one token, or two when pair is set.
	typedef struct packed {
		logic pair;
		tok_t first;
		tok_t second;
	} rec_t;

	// Queue status seen by its two neighbours.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Character byte to class.
	function automatic cls_t classify(logic [7:0] c);
		cls_t r;
		r = CLS_OTHER;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
			r = CLS_IDENT;
		else if (c >= "0" && c <= "9")
			r = CLS_DIGIT;
		else if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0D || c == 8'h0A)
			r = CLS_SPACE;
		else if (c == "!")
			r = CLS_NOT;
		else if (c == "(")
			r = CLS_LPAREN;
		else if (c == ")")
			r = CLS_RPAREN;
		else if (c == "&")
			r = CLS_AMP;
		else if (c == "|")
			r = CLS_BAR;
		return r;
	endfunction

	// Kind of the pending token when it closes; a lone operator is an error.
	function automatic kind_t pending_kind(cls_t c, logic [1:0] run);
		kind_t k;
		unique case (c)
			CLS_IDENT:  k = KIND_IDENT;
			CLS_NOT:    k = KIND_NOT;
			CLS_LPAREN: k = KIND_LPAREN;
			CLS_RPAREN: k = KIND_RPAREN;
			CLS_AMP:    k = (run == 2'd2) ? KIND_AND : KIND_ERROR;
			default:    k = (run == 2'd2) ? KIND_OR : KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

>>> sv/bet_front.sv
// ----------------------------------------------------------------------------
// bet_front
// Accepts one character or end mark per cycle while in_fire is set, classifies it, updates the
// tokenizer state and pushes the tokens it closes as one record.
// ----------------------------------------------------------------------------
module bet_front #(
	parameter int unsigned POS_BITS = bet_pkg::POS_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [7:0]      char_code,
	input  logic            end_flag,
	output logic            push,
	output bet_pkg::rec_t   push_rec
);
	import bet_pkg::*;

	localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] PosMax = '1;

	cls_t                 prior_class_q, prior_class_d;
	logic [1:0]           operator_run_q, operator_run_d;
	logic                 halted_q, halted_d;
	logic [POS_BITS-1:0]  begin_line_q, begin_line_d, begin_column_q, begin_column_d;
	logic [POS_BITS-1:0]  now_line_q, now_line_d, now_column_q, now_column_d;
	logic [POS_BITS-1:0]  prior_line_q, prior_line_d, prior_column_q, prior_column_d;
	cls_t                 cls_in;
	logic                 is_op_prior;

	function automatic tok_t mk_tok(kind_t k, logic [POS_BITS-1:0] fl,
			logic [POS_BITS-1:0] fc, logic [POS_BITS-1:0] ll,
			logic [POS_BITS-1:0] lc);
		tok_t t;
		t.kind         = k;
		t.first_line   = OUT_POS_W'(fl);
		t.first_column = OUT_POS_W'(fc);
		t.final_line   = OUT_POS_W'(ll);
		t.final_column = OUT_POS_W'(lc);
		return t;
	endfunction

	assign cls_in      = classify(char_code);
	assign is_op_prior = (prior_class_q == CLS_AMP) || (prior_class_q == CLS_BAR);

	// Next state and the record of closed tokens for the current item.
	always_comb begin
		prior_class_d  = prior_class_q;
		operator_run_d = operator_run_q;
		halted_d       = halted_q;
		begin_line_d   = begin_line_q;
		begin_column_d = begin_column_q;
		now_line_d     = now_line_q;
		now_column_d   = now_column_q;
		prior_line_d   = prior_line_q;
		prior_column_d = prior_column_q;
		push           = 1'b0;
		push_rec.pair  = 1'b0;
		push_rec.first = mk_tok(KIND_END, now_line_q, now_column_q, now_line_q, now_column_q);
		push_rec.second = push_rec.first;

		if (in_fire) begin
			if (end_flag) begin
				// Flush the pending token, then give the end token.
				push = 1'b1;
				if (!halted_q && prior_class_q != CLS_NONE) begin
					push_rec.pair  = 1'b1;
					push_rec.first = mk_tok(pending_kind(prior_class_q, operator_run_q),
						begin_line_q, begin_column_q, prior_line_q, prior_column_q);
				end
				prior_class_d  = CLS_NONE;
				operator_run_d = 2'd0;
				halted_d       = 1'b0;
				begin_line_d   = PosOne;
				begin_column_d = PosOne;
				now_line_d     = PosOne;
				now_column_d   = PosOne;
				prior_line_d   = PosOne;
				prior_column_d = PosOne;
			end else begin
				// Positions advance on every character, saturating.
				if (char_code == 8'h0A) begin
					if (now_line_q != PosMax)
						now_line_d = now_line_q + PosOne;
					now_column_d = PosOne;
				end else if (now_column_q != PosMax) begin
					now_column_d = now_column_q + PosOne;
				end

				if (!halted_q) begin
					priority if (cls_in == CLS_OTHER ||
							(cls_in == CLS_DIGIT && prior_class_q != CLS_IDENT)) begin
						// Character outside the alphabet or a leading digit.
						push           = 1'b1;
						push_rec.first = mk_tok(KIND_ERROR, now_line_q, now_column_q,
							now_line_q, now_column_q);
						halted_d       = 1'b1;
						prior_class_d  = CLS_NONE;
						operator_run_d = 2'd0;
					end else if (is_op_prior && cls_in == prior_class_q &&
							operator_run_q >= 2'd2) begin
						// Third character of an operator run.
						push           = 1'b1;
						push_rec.first = mk_tok(KIND_ERROR, begin_line_q, begin_column_q,
							now_line_q, now_column_q);
						halted_d       = 1'b1;
						prior_class_d  = CLS_NONE;
						operator_run_d = 2'd0;
					end else if (is_op_prior && cls_in == prior_class_q) begin
						operator_run_d = 2'd2;
						prior_line_d   = now_line_q;
						prior_column_d = now_column_q;
					end else if (is_op_prior && operator_run_q < 2'd2) begin
						// Lone operator followed by something else.
						push           = 1'b1;
						push_rec.first = mk_tok(KIND_ERROR, begin_line_q, begin_column_q,
							prior_line_q, prior_column_q);
						halted_d       = 1'b1;
						prior_class_d  = CLS_NONE;
						operator_run_d = 2'd0;
					end else if (prior_class_q == CLS_IDENT &&
							(cls_in == CLS_IDENT || cls_in == CLS_DIGIT)) begin
						prior_line_d   = now_line_q;
						prior_column_d = now_column_q;
					end else begin
						// Close the pending token and open a new one.
						if (prior_class_q != CLS_NONE) begin
							push           = 1'b1;
							push_rec.first = mk_tok(pending_kind(prior_class_q, operator_run_q),
								begin_line_q, begin_column_q, prior_line_q, prior_column_q);
						end
						if (cls_in == CLS_SPACE) begin
							prior_class_d  = CLS_NONE;
							operator_run_d = 2'd0;
						end else begin
							prior_class_d  = cls_in;
							operator_run_d = (cls_in == CLS_AMP || cls_in == CLS_BAR) ?
								2'd1 : 2'd0;
							begin_line_d   = now_line_q;
							begin_column_d = now_column_q;
							prior_line_d   = now_line_q;
							prior_column_d = now_column_q;
						end
					end
				end
			end
		end
	end

	// Tokenizer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_class_q  <= CLS_NONE;
			operator_run_q <= 2'd0;
			halted_q       <= 1'b0;
			begin_line_q   <= PosOne;
			begin_column_q <= PosOne;
			now_line_q     <= PosOne;
			now_column_q   <= PosOne;
			prior_line_q   <= PosOne;
			prior_column_q <= PosOne;
		end else begin
			prior_class_q  <= prior_class_d;
			operator_run_q <= operator_run_d;
			halted_q       <= halted_d;
			begin_line_q   <= begin_line_d;
			begin_column_q <= begin_column_d;
			now_line_q     <= now_line_d;
			now_column_q   <= now_column_d;
			prior_line_q   <= prior_line_d;
			prior_column_q <= prior_column_d;
		end
	end

endmodule

>>> sv/bet_queue.sv
// ----------------------------------------------------------------------------
// bet_queue
// Short first-in first-out queue of token records between the front and
// back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bet_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bet_pkg::rec_t       push_rec,
	input  logic                pop,
	output bet_pkg::rec_t       head_rec,
	output bet_pkg::q_stat_t    stat
);
	import bet_pkg::*;

	rec_t                 slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign head_rec   = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));

	// Record storage.
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_rec;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> sv/bet_back.sv
// ----------------------------------------------------------------------------
// bet_back
// Takes records from the queue and hands their tokens one per cycle, while the
// output register can load, to that register, marking the last token of each record.
// ----------------------------------------------------------------------------
module bet_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bet_pkg::rec_t       head_rec,
	input  bet_pkg::q_stat_t    stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bet_pkg::tok_t       out_tok,
	output logic                out_last
);
	import bet_pkg::*;

	logic out_valid_q;
	logic sel_q;
	logic load;
	logic take;
	logic head_last;
	tok_t tok_q;
	logic last_q;

	// The output register may refill when empty or when its token leaves.
	assign load      = !out_valid_q || out_ready;
	assign take      = load && !stat.empty;
	assign head_last = !head_rec.pair || sel_q;
	assign pop       = take && head_last;

	assign out_valid = out_valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	// Control: valid flag and position within the head record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (take)
				sel_q <= !head_last;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= sel_q ? head_rec.second : head_rec.first;
			last_q <= head_last;
		end
	end

endmodule

>>> sv/boolean_expr_tokenizer.sv
// ----------------------------------------------------------------------------
// boolean_expr_tokenizer
// Tokenizer for boolean expressions: identifiers, !, (, ), && and ||.
// ----------------------------------------------------------------------------
// The block takes one character byte, or an end-of-input mark, in every cycle
// while its queue has room, and gives identifier, operator, error and end
// tokens with the line and column of their first and last characters. The
// front part decides all tokens an item closes in the cycle it is accepted and
// queues them as one record; a two-record queue and an output register part it
// from the result channel. Results leave at one per cycle while out_ready is
// set, so the sustained rate is then one item per cycle while each item closes
// at most one token; an item that closes two (end of input with a token
// pending) gives them one after the other. A result is registered in the queue
// and then in the output register before it is valid. Line and column
// counters are POS_BITS wide and saturate at their maximum; the result fields
// carry their low 16 bits.
module boolean_expr_tokenizer #(
	parameter int unsigned POS_BITS = bet_pkg::POS_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   char_code,
	input  logic         end_flag,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   token_kind,
	output logic [15:0]  first_line,
	output logic [15:0]  first_column,
	output logic [15:0]  final_line,
	output logic [15:0]  final_column,
	output logic         run_last
);
	import bet_pkg::*;

	logic     in_fire;
	logic     push;
	rec_t     push_rec;
	logic     pop;
	rec_t     head_rec;
	q_stat_t  stat;
	tok_t     out_tok;

	// Items are taken whenever the queue has room for their record.
	assign in_ready = !stat.full;
	assign in_fire  = in_valid && in_ready;

	bet_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.char_code (char_code),
		.end_flag  (end_flag),
		.push      (push),
		.push_rec  (push_rec)
	);

	bet_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.stat     (stat)
	);

	bet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_rec  (head_rec),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (out_tok),
		.out_last  (run_last)
	);

	// Result fields.
	assign token_kind   = out_tok.kind;
	assign first_line   = out_tok.first_line;
	assign first_column = out_tok.first_column;
	assign final_line   = out_tok.final_line;
	assign final_column = out_tok.final_column;

endmodule

>>> tb/tb_boolean_expr_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_boolean_expr_tokenizer
// Self-checking testbench of the boolean expression tokenizer.
// ----------------------------------------------------------------------------
// Characters and end-of-input marks are fed through the input handshake. A
// tokenizer model inside the testbench works out the tokens that each accepted
// item closes, and every token leaving the block is compared field by field
// with the oldest one still awaited. The run covers a directed set of token
// and error cases, a long output stall and a random mix of well-formed
// expressions, broken expressions and noise, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_boolean_expr_tokenizer;
	import bet_pkg::*;

	// Whitespace and line break bytes.
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_NL  = 8'h0A;

	// Positions stop at the top of the 16-bit range.
	localparam logic [15:0] POS_TOP = 16'hFFFF;

	// Cycles without any handshake before the run is abandoned.
	localparam int unsigned STALL_LIMIT = 3000;

	// Number of random items to send.
	localparam int unsigned RANDOM_ITEMS = 1750;

	// One expected token.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] fl;
		logic [15:0] fc;
		logic [15:0] ll;
		logic [15:0] lc;
		logic        last;
	} token_exp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        end_flag;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  token_kind;
	logic [15:0] first_line;
	logic [15:0] first_column;
	logic [15:0] final_line;
	logic [15:0] final_column;
	logic        run_last;

	boolean_expr_tokenizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_flag     (end_flag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.first_line   (first_line),
		.first_column (first_column),
		.final_line   (final_line),
		.final_column (final_column),
		.run_last     (run_last)
	);

	// Tokens awaited from the block, oldest first.
	token_exp_t expected_tokens[$];

	// Tokenizer state as the model keeps it.
	cls_t        pend_cls;
	logic [1:0]  pend_run;
	logic        stopped;
	logic [15:0] tok_line, tok_col;
	logic [15:0] end_line, end_col;
	logic [15:0] cur_line, cur_col;

	// Run control and statistics.
	bit          send_idle;
	bit          recv_stall;
	int unsigned hold_len;
	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned ends_sent;
	int unsigned tokens_checked;
	int unsigned error_tokens;
	int unsigned quiet_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Tokenizer model
	// ------------------------------------------------------------------------

	// Byte to character class.
	function automatic cls_t char_class(logic [7:0] c);
		cls_t k;
		logic [7:0] lower;
		k = CLS_OTHER;
		lower = c | 8'h20;
		if (lower >= "a" && lower <= "z" && c < 8'h80)
			k = CLS_IDENT;
		else if (c >= "0" && c <= "9")
			k = CLS_DIGIT;
		else begin
			case (c)
				"_":                              k = CLS_IDENT;
				CH_SP, CH_TAB, CH_VT, CH_CR, CH_NL: k = CLS_SPACE;
				"!":                              k = CLS_NOT;
				"(":                              k = CLS_LPAREN;
				")":                              k = CLS_RPAREN;
				"&":                              k = CLS_AMP;
				"|":                              k = CLS_BAR;
				default:                          k = CLS_OTHER;
			endcase
		end
		return k;
	endfunction

	// Kind of the pending token when it closes; a lone & or | is an error.
	function automatic kind_t close_kind();
		kind_t k;
		case (pend_cls)
			CLS_IDENT:  k = KIND_IDENT;
			CLS_NOT:    k = KIND_NOT;
			CLS_LPAREN: k = KIND_LPAREN;
			CLS_RPAREN: k = KIND_RPAREN;
			CLS_AMP:    k = (pend_run == 2'd2) ? KIND_AND : KIND_ERROR;
			default:    k = (pend_run == 2'd2) ? KIND_OR : KIND_ERROR;
		endcase
		return k;
	endfunction

	function automatic void predictor_clear();
		pend_cls = CLS_NONE;
		pend_run = 2'd0;
		stopped  = 1'b0;
		tok_line = 16'd1;
		tok_col  = 16'd1;
		end_line = 16'd1;
		end_col  = 16'd1;
		cur_line = 16'd1;
		cur_col  = 16'd1;
	endfunction

	function automatic void push_token(kind_t k, logic [15:0] fl, logic [15:0] fc,
			logic [15:0] ll, logic [15:0] lc);
		token_exp_t t;
		t.kind = k;
		t.fl   = fl;
		t.fc   = fc;
		t.ll   = ll;
		t.lc   = lc;
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	// An error token ends the item and silences the block until end of input.
	function automatic void raise_error(logic [15:0] fl, logic [15:0] fc,
			logic [15:0] ll, logic [15:0] lc);
		push_token(KIND_ERROR, fl, fc, ll, lc);
		expected_tokens[expected_tokens.size()-1].last = 1'b1;
		stopped  = 1'b1;
		pend_cls = CLS_NONE;
		pend_run = 2'd0;
	endfunction

	// Works out the tokens that one accepted item closes.
	function automatic void tokenize_item(logic [7:0] c, logic fin);
		cls_t        cls;
		logic [15:0] at_line, at_col;
		int unsigned base;
		base = expected_tokens.size();

		// End of input: flush the pending token, then the end token.
		if (fin) begin
			if (!stopped && pend_cls != CLS_NONE)
				push_token(close_kind(), tok_line, tok_col, end_line, end_col);
			push_token(KIND_END, cur_line, cur_col, cur_line, cur_col);
			expected_tokens[expected_tokens.size()-1].last = 1'b1;
			predictor_clear();
			return;
		end

		// Positions advance on every character, even after an error.
		at_line = cur_line;
		at_col  = cur_col;
		if (c == CH_NL) begin
			if (cur_line != POS_TOP)
				cur_line++;
			cur_col = 16'd1;
		end else if (cur_col != POS_TOP) begin
			cur_col++;
		end
		if (stopped)
			return;

		cls = char_class(c);

		// Foreign characters and digits that start a token.
		if (cls == CLS_OTHER || (cls == CLS_DIGIT && pend_cls != CLS_IDENT)) begin
			raise_error(at_line, at_col, at_line, at_col);
			return;
		end

		// Runs of & or |, and identifiers that grow.
		if (pend_cls == CLS_AMP || pend_cls == CLS_BAR) begin
			if (cls == pend_cls) begin
				if (pend_run == 2'd2) begin
					raise_error(tok_line, tok_col, at_line, at_col);
					return;
				end
				pend_run = 2'd2;
				end_line = at_line;
				end_col  = at_col;
				return;
			end
			if (pend_run != 2'd2) begin
				raise_error(tok_line, tok_col, end_line, end_col);
				return;
			end
		end else if (pend_cls == CLS_IDENT && (cls == CLS_IDENT || cls == CLS_DIGIT)) begin
			end_line = at_line;
			end_col  = at_col;
			return;
		end

		// The pending token closes and the new character opens the next.
		if (pend_cls != CLS_NONE)
			push_token(close_kind(), tok_line, tok_col, end_line, end_col);
		if (cls == CLS_SPACE) begin
			pend_cls = CLS_NONE;
			pend_run = 2'd0;
		end else begin
			pend_cls = cls;
			pend_run = (cls == CLS_AMP || cls == CLS_BAR) ? 2'd1 : 2'd0;
			tok_line = at_line;
			tok_col  = at_col;
			end_line = at_line;
			end_col  = at_col;
		end
		if (expected_tokens.size() > base)
			expected_tokens[expected_tokens.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_token();
		token_exp_t want;
		if (expected_tokens.size() == 0) begin
			log_failure($sformatf("token kind %0d at %0d:%0d with none awaited",
				token_kind, first_line, first_column));
			return;
		end
		want = expected_tokens.pop_front();
		tokens_checked++;
		if (want.kind == KIND_ERROR)
			error_tokens++;
		if (token_kind !== want.kind || first_line !== want.fl ||
				first_column !== want.fc || final_line !== want.ll ||
				final_column !== want.lc || run_last !== want.last)
			log_failure({
				$sformatf("mismatch: expected kind %0d %0d:%0d-%0d:%0d last %0b, ",
					want.kind, want.fl, want.fc, want.ll, want.lc, want.last),
				$sformatf("got kind %0d %0d:%0d-%0d:%0d last %0b",
					token_kind, first_line, first_column, final_line, final_column,
					run_last)});
	endfunction

	// Both channels are sampled at the clock edge, inputs before outputs.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tokenize_item(char_code, end_flag);
			if (out_valid && out_ready)
				check_token();
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a handshake", quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver
	// ------------------------------------------------------------------------

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (recv_stall && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offers one item and returns at the edge where it is taken.
	task automatic send_char(logic [7:0] c, logic fin);
		int unsigned gap;
		gap = send_idle ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		end_flag  <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (fin)
			ends_sent++;
	endtask

	// The character byte rides along with the end mark but is ignored.
	task automatic send_end();
		send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	function automatic logic [7:0] ident_char(bit lead);
		int unsigned r;
		r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] space_char();
		case ($urandom_range(0, 4))
			0:       return CH_SP;
			1:       return CH_TAB;
			2:       return CH_VT;
			3:       return CH_CR;
			default: return CH_NL;
		endcase
	endfunction

	// One random well-formed token.
	task automatic send_token();
		int unsigned len;
		case ($urandom_range(0, 5))
			0: begin
				len = $urandom_range(1, 6);
				send_char(ident_char(1'b1), 1'b0);
				for (int i = 1; i < len; i++)
					send_char(ident_char(1'b0), 1'b0);
			end
			1: send_text("!");
			2: send_text("(");
			3: send_text(")");
			4: send_text("&&");
			default: send_text("||");
		endcase
	endtask

	// Tokens separated by whitespace runs, sometimes by nothing.
	task automatic send_tokens(int unsigned count);
		for (int i = 0; i < count; i++) begin
			if (i > 0 && $urandom_range(0, 2) != 0) begin
				repeat ($urandom_range(1, 3))
					send_char(space_char(), 1'b0);
			end
			send_token();
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Every token kind, whitespace, and each way of ending in an error.
	task automatic test_directed();
		send_idle  = 1'b1;
		recv_stall = 1'b1;
		send_text("_aZ9");
		send_char(CH_TAB, 1'b0);
		send_text("(!b)&&c||Y");
		send_char(CH_NL, 1'b0);
		send_text(")");
		send_end();
		// Lone & followed by another operator; later input is ignored.
		send_text("&|x");
		send_end();
		// Three bars in a row.
		send_text("|||");
		send_end();
		// A digit cannot open a token.
		send_char(CH_VT, 1'b0);
		send_char(CH_CR, 1'b0);
		send_text("9");
		send_end();
		// A foreign byte drops the pending identifier.
		send_text("a");
		send_char(8'hFF, 1'b0);
		send_end();
		send_char(8'h00, 1'b0);
		send_end();
		// A lone & flushed by end of input, then an empty stream.
		send_text("&");
		send_end();
		send_end();
	endtask

	// The receiver stops for a long stretch while items keep coming.
	task automatic test_back_pressure();
		send_idle  = 1'b0;
		recv_stall = 1'b0;
		hold_len   = 300;
		repeat (8) begin
			send_tokens($urandom_range(4, 10));
			send_end();
		end
	endtask

	// Mostly well-formed expressions, some broken ones and some noise.
	task automatic test_random();
		int unsigned stop_at;
		int unsigned r;
		string noise_set;
		noise_set = "&|!()a9# ";
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			// Some sequences run without any gaps.
			if ($urandom_range(0, 4) == 0) begin
				send_idle  = 1'b0;
				recv_stall = 1'b0;
			end else begin
				send_idle  = 1'b1;
				recv_stall = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_tokens($urandom_range(1, 12));
			end else if (r < 90) begin
				send_tokens($urandom_range(0, 4));
				case ($urandom_range(0, 4))
					0: begin
						send_text("&");
						send_char(ident_char(1'b1), 1'b0);
					end
					1: send_text("|||");
					2: send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
					3: send_char(8'($urandom_range(0, 255)), 1'b0);
					default: send_text("&|");
				endcase
				send_tokens($urandom_range(0, 3));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1) == 0)
						send_char(8'($urandom_range(0, 255)), 1'b0);
					else
						send_char(noise_set[$urandom_range(0, noise_set.len() - 1)], 1'b0);
				end
			end
			send_end();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		char_code      = 8'h00;
		end_flag       = 1'b0;
		send_idle      = 1'b0;
		recv_stall     = 1'b0;
		hold_len       = 0;
		fail_count     = 0;
		items_sent     = 0;
		ends_sent      = 0;
		tokens_checked = 0;
		error_tokens   = 0;
		quiet_cycles   = 0;
		predictor_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_back_pressure();
		test_random();
		in_valid <= 1'b0;

		// Drain, then allow for any token that should not come.
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d items with %0d end marks, %0d tokens checked (%0d errors).",
			items_sent, ends_sent, tokens_checked, error_tokens);
		$display("Included directed error cases, a long output stall and random gaps.");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
sv/bet_pkg.sv
sv/bet_front.sv
sv/bet_queue.sv
sv/bet_back.sv
sv/boolean_expr_tokenizer.sv
tb/tb_boolean_expr_tokenizer.sv
